FILE: rtl/core/dhfk_pkg.sv
// ----------------------------------------------------------------------------
// dhfk_pkg
// Types, constants and small helper functions shared by the DH kinematics core.
// ----------------------------------------------------------------------------
package dhfk_pkg;

  // one joint as it waits in the input queue
  typedef struct packed {
    logic signed [15:0] twist;
    logic signed [31:0] len;
    logic signed [15:0] theta;
    logic signed [31:0] offs;
    logic               start;
  } item_t;

  localparam int QDEPTH = 2;
  localparam int ATAN_IW = 5;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [16:0] HALF_PI_Q13 = 17'sd12868;
  localparam logic signed [16:0] PI_Q13      = 17'sd25736;

  localparam logic signed [65:0] ONE_Q30  = 66'sd1073741824;
  localparam logic signed [65:0] HALF_Q30 = 66'sd536870912;
  localparam logic signed [65:0] P40_MAX  = 66'sd549755813887;
  localparam logic signed [65:0] P40_MIN  = -66'sd549755813888;
  localparam logic signed [39:0] P32_MAX  = 40'sd2147483647;
  localparam logic signed [39:0] P32_MIN  = -40'sd2147483648;

  // matrix sequencer: 6 joint-transform products, 9 position, 27 rotation
  localparam int N_TRIG  = 6;
  localparam int N_POS   = 9;
  localparam int N_ROT   = 27;
  localparam int N_STEPS = N_TRIG + N_POS + N_ROT;
  localparam int KW      = 6;

  typedef enum logic [1:0] {
    K_TRIG = 2'd0,
    K_POS  = 2'd1,
    K_ROT  = 2'd2
  } kind_t;

  // trig product destinations
  localparam logic [3:0] D_RJ1 = 4'd0;
  localparam logic [3:0] D_RJ2 = 4'd1;
  localparam logic [3:0] D_RJ4 = 4'd2;
  localparam logic [3:0] D_RJ5 = 4'd3;
  localparam logic [3:0] D_PJ0 = 4'd4;
  localparam logic [3:0] D_PJ1 = 4'd5;

  // trig operand selects
  localparam logic [3:0] A_ST = 4'd0;
  localparam logic [3:0] A_CT = 4'd1;
  localparam logic [3:0] B_CA = 4'd0;
  localparam logic [3:0] B_SA = 4'd1;
  localparam logic [3:0] B_LEN = 4'd2;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] asel;
    logic [3:0] bsel;
    logic [3:0] dst;
    logic       first;
    logic       last;
  } step_t;

  function automatic step_t step_dec(input logic [KW-1:0] k);
    step_t d;
    d       = '0;
    d.kind  = K_TRIG;
    d.first = 1'b1;
    d.last  = 1'b1;
    d.dst   = 4'(k);
    d.asel  = (k == 6'd0 || k == 6'd1 || k == 6'd5) ? A_ST : A_CT;
    d.bsel  = (k == 6'd0 || k == 6'd2) ? B_CA :
              ((k == 6'd1 || k == 6'd3) ? B_SA : B_LEN);
    for (int i = 0; i < N_POS; i++) begin
      if (k == KW'(N_TRIG + i)) begin
        d.kind  = K_POS;
        d.asel  = 4'(i);
        d.bsel  = 4'(i % 3);
        d.dst   = 4'(i / 3);
        d.first = (i % 3) == 0;
        d.last  = (i % 3) == 2;
      end
    end
    for (int i = 0; i < N_ROT; i++) begin
      if (k == KW'(N_TRIG + N_POS + i)) begin
        d.kind  = K_ROT;
        d.asel  = 4'((i / 9) * 3 + (i % 3));
        d.bsel  = 4'(3 * (i % 3) + (i / 3) % 3);
        d.dst   = 4'((i / 9) * 3 + (i / 3) % 3);
        d.first = (i % 3) == 0;
        d.last  = (i % 3) == 2;
      end
    end
    return d;
  endfunction

  function automatic logic signed [33:0] atan_q30(input logic [ATAN_IW-1:0] i);
    logic signed [33:0] v;
    case (i)
      5'd0:  v = 34'sd843314857;
      5'd1:  v = 34'sd497837829;
      5'd2:  v = 34'sd263043836;
      5'd3:  v = 34'sd133525158;
      5'd4:  v = 34'sd67021686;
      5'd5:  v = 34'sd33543515;
      5'd6:  v = 34'sd16775850;
      5'd7:  v = 34'sd8388437;
      5'd8:  v = 34'sd4194282;
      5'd9:  v = 34'sd2097149;
      5'd10: v = 34'sd1048575;
      5'd11: v = 34'sd524287;
      5'd12: v = 34'sd262143;
      5'd13: v = 34'sd131071;
      5'd14: v = 34'sd65535;
      5'd15: v = 34'sd32767;
      5'd16: v = 34'sd16383;
      5'd17: v = 34'sd8191;
      5'd18: v = 34'sd4095;
      5'd19: v = 34'sd2047;
      5'd20: v = 34'sd1023;
      5'd21: v = 34'sd511;
      5'd22: v = 34'sd255;
      5'd23: v = 34'sd127;
      5'd24: v = 34'sd63;
      5'd25: v = 34'sd31;
      5'd26: v = 34'sd15;
      5'd27: v = 34'sd8;
      5'd28: v = 34'sd4;
      5'd29: v = 34'sd2;
      5'd30: v = 34'sd1;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

  // round half up from Q.60 to Q.30
  function automatic logic signed [65:0] rnd30(input logic signed [65:0] v);
    return (v + HALF_Q30) >>> 30;
  endfunction

  function automatic logic signed [31:0] clamp_q30(input logic signed [65:0] v);
    logic signed [65:0] t;
    t = (v > ONE_Q30) ? ONE_Q30 : ((v < -ONE_Q30) ? -ONE_Q30 : v);
    return t[31:0];
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [65:0] v);
    logic signed [65:0] t;
    t = (v > P40_MAX) ? P40_MAX : ((v < P40_MIN) ? P40_MIN : v);
    return t[39:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [39:0] t;
    t = (v > P32_MAX) ? P32_MAX : ((v < P32_MIN) ? P32_MIN : v);
    return t[31:0];
  endfunction

endpackage

FILE: rtl/core/dhfk_front.sv
// ----------------------------------------------------------------------------
// dhfk_front
// Input side: accepts joint words and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module dhfk_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [95:0]           in_tdata,
  input  logic                  in_tuser,
  input  logic                  pop,
  output logic                  q_valid,
  output dhfk_pkg::item_t       q_item
);

  dhfk_pkg::item_t mem_r [dhfk_pkg::QDEPTH];
  logic            wp_r, wp_nxt;
  logic            rp_r, rp_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            push, take;
  dhfk_pkg::item_t w_item;

  assign in_tready = cnt_r != 2'(dhfk_pkg::QDEPTH);
  assign q_valid   = cnt_r != 2'd0;
  assign q_item    = mem_r[rp_r];
  assign push      = in_tvalid && in_tready;
  assign take      = pop && q_valid;

  always_comb begin
    w_item.twist = $signed(in_tdata[15:0]);
    w_item.len   = $signed(in_tdata[47:16]);
    w_item.theta = $signed(in_tdata[63:48]);
    w_item.offs  = $signed(in_tdata[95:64]);
    w_item.start = in_tuser;
  end

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = take ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= w_item;
    end
  end

endmodule

FILE: rtl/core/dhfk_cordic.sv
// ----------------------------------------------------------------------------
// dhfk_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, Q3.13 in,
// Q2.30 sine and cosine out.
// ----------------------------------------------------------------------------
module dhfk_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [15:0] ang,
  output logic               done,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);

  localparam logic [dhfk_pkg::ATAN_IW-1:0] LAST = dhfk_pkg::ATAN_IW'(CORDIC_STEPS - 1);

  logic signed [33:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [dhfk_pkg::ATAN_IW-1:0] i_r;
  logic               run_r, flip_r, done_r;
  logic signed [31:0] sin_r, cos_r;
  logic signed [16:0] a17, red;
  logic               flip_in;
  logic signed [65:0] xf, yf;

  // fold into [-pi/2, pi/2], negate results afterwards
  always_comb begin
    a17     = 17'(ang);
    red     = a17;
    flip_in = 1'b0;
    if (a17 > dhfk_pkg::HALF_PI_Q13) begin
      red     = a17 - dhfk_pkg::PI_Q13;
      flip_in = 1'b1;
    end else if (a17 < -dhfk_pkg::HALF_PI_Q13) begin
      red     = a17 + dhfk_pkg::PI_Q13;
      flip_in = 1'b1;
    end
  end

  always_comb begin
    if (z_r >= 0) begin
      x_nxt = x_r - (y_r >>> i_r);
      y_nxt = y_r + (x_r >>> i_r);
      z_nxt = z_r - dhfk_pkg::atan_q30(i_r);
    end else begin
      x_nxt = x_r + (y_r >>> i_r);
      y_nxt = y_r - (x_r >>> i_r);
      z_nxt = z_r + dhfk_pkg::atan_q30(i_r);
    end
    xf = flip_r ? -66'(x_nxt) : 66'(x_nxt);
    yf = flip_r ? -66'(y_nxt) : 66'(y_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        i_r   <= '0;
      end else if (run_r) begin
        i_r <= i_r + 1'b1;
        if (i_r == LAST) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= dhfk_pkg::CORDIC_GAIN;
      y_r    <= '0;
      z_r    <= $signed({red, 17'd0});
      flip_r <= flip_in;
    end else if (run_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
      if (i_r == LAST) begin
        cos_r <= dhfk_pkg::clamp_q30(xf);
        sin_r <= dhfk_pkg::clamp_q30(yf);
      end
    end
  end

  assign done  = done_r;
  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

FILE: rtl/core/dhfk_back.sv
// ----------------------------------------------------------------------------
// dhfk_back
// Execution side: sequences the two CORDIC passes, runs the 42 products of the
// joint transform and the chain update on one multiplier, holds the result.
// ----------------------------------------------------------------------------
module dhfk_back #(
  parameter int CORDIC_STEPS = 16,
  parameter int MAX_JOINTS   = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  dhfk_pkg::item_t q_item,
  output logic            pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [103:0]    out_tdata
);

  localparam int CAP_I = (MAX_JOINTS - 1 < 15) ? MAX_JOINTS - 1 : 15;
  localparam logic [3:0] CAP = 4'(CAP_I);
  localparam logic [dhfk_pkg::KW-1:0] K_LAST = dhfk_pkg::KW'(dhfk_pkg::N_STEPS - 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ALPHA = 6'b000010,
    S_THETA = 6'b000100,
    S_MAT   = 6'b001000,
    S_DRAIN = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r;
  dhfk_pkg::item_t item_r;

  logic               c_start, c_done;
  logic signed [15:0] c_ang;
  logic signed [31:0] c_sin, c_cos;

  logic signed [31:0] sa_r, ca_r, st_r, ct_r;
  logic signed [31:0] rj1_r, rj2_r, rj4_r, rj5_r;
  logic signed [32:0] pj0_r, pj1_r;
  logic signed [31:0] rot_r [9];
  logic signed [31:0] nr_r  [9];
  logic signed [39:0] pos_r [3];
  logic [3:0]         cnt_r;

  logic [dhfk_pkg::KW-1:0] k_r;
  dhfk_pkg::step_t    dec, dec_d_r;
  logic               vld_d_r;
  logic signed [31:0] op_a;
  logic signed [32:0] op_b;
  logic signed [65:0] prod_r, acc_r, rp, sum;
  logic signed [31:0] rj_sel;

  logic               out_valid_r;
  logic [103:0]       out_data_r;
  logic               out_free;

  assign out_free = !out_valid_r || out_tready;
  assign pop      = (state_r == S_IDLE) && q_valid;
  assign c_start  = pop || ((state_r == S_ALPHA) && c_done);
  assign c_ang    = (state_r == S_IDLE) ? q_item.twist : item_r.theta;

  dhfk_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk  (clk),
    .rst_n(rst_n),
    .start(c_start),
    .ang  (c_ang),
    .done (c_done),
    .sin_o(c_sin),
    .cos_o(c_cos)
  );

  // operand selection for the single multiplier
  assign dec = dhfk_pkg::step_dec(k_r);

  always_comb begin
    case (dec.bsel)
      4'd0:    rj_sel = ct_r;
      4'd1:    rj_sel = rj1_r;
      4'd2:    rj_sel = rj2_r;
      4'd3:    rj_sel = st_r;
      4'd4:    rj_sel = rj4_r;
      4'd5:    rj_sel = rj5_r;
      4'd7:    rj_sel = sa_r;
      4'd8:    rj_sel = ca_r;
      default: rj_sel = '0;
    endcase
  end

  always_comb begin
    op_a = rot_r[dec.asel];
    op_b = 33'(rj_sel);
    case (dec.kind)
      dhfk_pkg::K_TRIG: begin
        op_a = (dec.asel == dhfk_pkg::A_ST) ? st_r : ct_r;
        case (dec.bsel)
          dhfk_pkg::B_CA: op_b = 33'(ca_r);
          dhfk_pkg::B_SA: op_b = 33'(sa_r);
          default:        op_b = 33'(item_r.len);
        endcase
      end
      dhfk_pkg::K_POS: begin
        case (dec.bsel)
          4'd0:    op_b = pj0_r;
          4'd1:    op_b = pj1_r;
          default: op_b = 33'(item_r.offs);
        endcase
      end
      default: ;
    endcase
  end

  // accumulate stage, fed by the registered product and the delayed step decode
  always_comb begin
    rp  = dhfk_pkg::rnd30(prod_r);
    sum = (dec_d_r.first ? 66'sd0 : acc_r) +
          ((dec_d_r.kind == dhfk_pkg::K_ROT) ? prod_r : rp);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_d_r     <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      for (int i = 0; i < 9; i++) begin
        rot_r[i] <= (i % 4 == 0) ? 32'sd1073741824 : 32'sd0;
      end
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= '0;
      end
    end else begin
      vld_d_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            if (q_item.start) begin
              cnt_r <= '0;
              for (int i = 0; i < 9; i++) begin
                rot_r[i] <= (i % 4 == 0) ? 32'sd1073741824 : 32'sd0;
              end
              for (int i = 0; i < 3; i++) begin
                pos_r[i] <= '0;
              end
            end
            state_r <= S_ALPHA;
          end
        end
        S_ALPHA: begin
          if (c_done) begin
            state_r <= S_THETA;
          end
        end
        S_THETA: begin
          if (c_done) begin
            k_r     <= '0;
            state_r <= S_MAT;
          end
        end
        S_MAT: begin
          vld_d_r <= 1'b1;
          k_r     <= k_r + 1'b1;
          if (k_r == K_LAST) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          for (int i = 0; i < 9; i++) begin
            rot_r[i] <= nr_r[i];
          end
          if (out_free) begin
            if (cnt_r < CAP) begin
              cnt_r <= cnt_r + 1'b1;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (vld_d_r && dec_d_r.last && dec_d_r.kind == dhfk_pkg::K_POS) begin
        pos_r[dec_d_r.dst[1:0]] <= dhfk_pkg::sat40(66'(pos_r[dec_d_r.dst[1:0]]) + sum);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (pop) begin
      item_r <= q_item;
    end
    if (c_done && state_r == S_ALPHA) begin
      sa_r <= c_sin;
      ca_r <= c_cos;
    end
    if (c_done && state_r == S_THETA) begin
      st_r <= c_sin;
      ct_r <= c_cos;
    end
    prod_r  <= 66'(op_a) * 66'(op_b);
    dec_d_r <= dec;
    if (vld_d_r) begin
      acc_r <= sum;
      case (dec_d_r.kind)
        dhfk_pkg::K_TRIG: begin
          case (dec_d_r.dst)
            dhfk_pkg::D_RJ1: rj1_r <= 32'(-rp);
            dhfk_pkg::D_RJ2: rj2_r <= rp[31:0];
            dhfk_pkg::D_RJ4: rj4_r <= rp[31:0];
            dhfk_pkg::D_RJ5: rj5_r <= 32'(-rp);
            dhfk_pkg::D_PJ0: pj0_r <= rp[32:0];
            dhfk_pkg::D_PJ1: pj1_r <= rp[32:0];
            default: ;
          endcase
        end
        dhfk_pkg::K_ROT: begin
          if (dec_d_r.last) begin
            nr_r[dec_d_r.dst] <= dhfk_pkg::clamp_q30(dhfk_pkg::rnd30(sum));
          end
        end
        default: ;
      endcase
    end
    if (state_r == S_DONE && out_free) begin
      out_data_r <= {4'd0, cnt_r, dhfk_pkg::sat32(pos_r[2]),
                     dhfk_pkg::sat32(pos_r[1]), dhfk_pkg::sat32(pos_r[0])};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: rtl/core/dh_forward_kinematics.sv
// ----------------------------------------------------------------------------
// dh_forward_kinematics
// Denavit-Hartenberg forward kinematics: one joint in, one joint position out.
// ----------------------------------------------------------------------------
// Each input word carries one joint's twist, link length, joint angle and
// offset; tuser set starts a new chain (identity transform, index 0). The
// block chains the joint transform into the kept pose and returns the joint's
// Q16.16 position and its index. Each joint takes two passes through one
// iterative CORDIC, one micro-rotation per cycle, then 42 products on a
// single multiplier. A two-word input queue and an output register let
// both sides stall freely.
module dh_forward_kinematics #(
  parameter int CORDIC_STEPS = 16,
  parameter int MAX_JOINTS   = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // twist_angle, link_length, joint_angle, link_offset
  input  logic         in_tuser,   // chain_start
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata   // pos_x, pos_y, pos_z, joint_index, zero pad
);

  logic            q_valid;
  logic            pop;
  dhfk_pkg::item_t q_item;

  dhfk_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_item   (q_item)
  );

  dhfk_back #(
    .CORDIC_STEPS(CORDIC_STEPS),
    .MAX_JOINTS  (MAX_JOINTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

endmodule
